// ===== rtl/tscb_pkg.sv =====
// ----------------------------------------------------------------------------
// tscb_pkg: shared types and constants of the text screen cell buffer
// Function codes, character and style codes, controller states, walker modes,
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tscb_pkg;

    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 128;

    localparam logic [3:0] FN_PUT     = 4'd0;
    localparam logic [3:0] FN_CURSOR  = 4'd1;
    localparam logic [3:0] FN_STYLE   = 4'd2;
    localparam logic [3:0] FN_PICTURE = 4'd3;
    localparam logic [3:0] FN_ERASE   = 4'd4;
    localparam logic [3:0] FN_SCROLL  = 4'd5;
    localparam logic [3:0] FN_READ    = 4'd6;
    localparam logic [3:0] FN_QUERY   = 4'd7;
    localparam logic [3:0] FN_CLEAR   = 4'd8;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_INDENT    = 8'h09;
    localparam logic [7:0] CH_GAP       = 8'h0B;
    localparam logic [7:0] CH_PRINT_MAX = 8'd126;
    localparam logic [7:0] CH_HIGH_MIN  = 8'hA0;

    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_PICTURE = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_RD,
        S_WR,
        S_MCLR,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        M_SET,
        M_MOVE,
        M_PUT,
        M_READ,
        M_QUERY
    } t_mode;

    typedef struct packed {
        logic accept;
        logic clr_init;
        logic setup;
        logic step;
        logic mclr;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic clr_last;
        logic work;
        logic mclr_req;
        logic last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/tscb_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tscb_cmd_if: command channel of the text screen cell buffer
// Valid/ready channel carrying one screen command.
// ----------------------------------------------------------------------------
interface tscb_cmd_if;
    logic              valid;
    logic              ready;
    logic [3:0]        func;
    logic [7:0]        char_code;
    logic [7:0]        style_word;
    logic [7:0]        row_top;
    logic [7:0]        col_left;
    logic [5:0]        row_bottom;
    logic [7:0]        col_right;
    logic signed [6:0] shift_units;

    modport source (
        output valid, func, char_code, style_word, row_top, col_left,
               row_bottom, col_right, shift_units,
        input  ready
    );
    modport sink (
        input  valid, func, char_code, style_word, row_top, col_left,
               row_bottom, col_right, shift_units,
        output ready
    );
endinterface

// ===== rtl/tscb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tscb_rsp_if: result channel of the text screen cell buffer
// Valid/ready channel carrying the cursor and the read or query answer.
// ----------------------------------------------------------------------------
interface tscb_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic [7:0] rd_char;
    logic [1:0] rd_style;
    logic       cell_changed;
    logic       row_changed;

    modport source (
        output valid, cursor_row_out, cursor_col_out, rd_char, rd_style,
               cell_changed, row_changed,
        input  ready
    );
    modport sink (
        input  valid, cursor_row_out, cursor_col_out, rd_char, rd_style,
               cell_changed, row_changed,
        output ready
    );
endinterface

// ===== rtl/tscb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tscb_ctrl: command sequencer of the text screen cell buffer
// Steps through reset clearing, command setup, cell read/write pairs,
// mark clearing and result hand-off.
// ----------------------------------------------------------------------------
module tscb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tscb_pkg::t_status i_sts,
    output tscb_pkg::t_cmd    o_cmd
);

    tscb_pkg::t_state r_state;
    tscb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tscb_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tscb_pkg::S_INIT: begin
                if (i_sts.clr_last) n_state = tscb_pkg::S_IDLE;
            end
            tscb_pkg::S_IDLE: begin
                if (i_sts.in_valid) n_state = tscb_pkg::S_SETUP;
            end
            tscb_pkg::S_SETUP: begin
                priority if (i_sts.mclr_req) n_state = tscb_pkg::S_MCLR;
                else if (i_sts.work)         n_state = tscb_pkg::S_RD;
                else                         n_state = tscb_pkg::S_RESP;
            end
            tscb_pkg::S_RD: n_state = tscb_pkg::S_WR;
            tscb_pkg::S_WR: begin
                n_state = i_sts.last ? tscb_pkg::S_RESP : tscb_pkg::S_RD;
            end
            tscb_pkg::S_MCLR: begin
                if (i_sts.clr_last) n_state = tscb_pkg::S_RESP;
            end
            tscb_pkg::S_RESP: begin
                if (i_sts.out_free) n_state = tscb_pkg::S_IDLE;
            end
            default: n_state = tscb_pkg::S_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tscb_pkg::S_INIT:  o_cmd.clr_init = 1'b1;
            tscb_pkg::S_IDLE:  o_cmd.accept   = 1'b1;
            tscb_pkg::S_SETUP: o_cmd.setup    = 1'b1;
            tscb_pkg::S_RD:    ;
            tscb_pkg::S_WR:    o_cmd.step     = 1'b1;
            tscb_pkg::S_MCLR:  o_cmd.mclr     = 1'b1;
            tscb_pkg::S_RESP:  o_cmd.load     = i_sts.out_free;
            default:           ;
        endcase
    end

endmodule

// ===== rtl/tscb_dp.sv =====
// ----------------------------------------------------------------------------
// tscb_dp: datapath of the text screen cell buffer
// Cell memories, cursor, rectangle walker and the result register.
// ----------------------------------------------------------------------------
module tscb_dp #(
    parameter int ROWS = tscb_pkg::ROWS_DEF,
    parameter int COLS = tscb_pkg::COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tscb_cmd_if.sink          i_cmd,
    tscb_rsp_if.source        o_rsp,
    input  tscb_pkg::t_cmd    i_ctl,
    output tscb_pkg::t_status o_sts
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam logic signed [9:0] ROW_MAX = 10'(ROWS - 1);
    localparam logic signed [9:0] COL_MAX = 10'(COLS - 1);

    // cell memories: {char, style} and the changed marks
    logic [9:0] mem_cs [DEPTH];
    logic       mem_mk [DEPTH];

    logic [3:0]        r_func;
    logic [7:0]        r_ch;
    logic              r_sty;
    logic [7:0]        r_rt;
    logic [7:0]        r_cl;
    logic [5:0]        r_rb;
    logic [7:0]        r_cr;
    logic signed [6:0] r_su;

    logic [RW-1:0] r_crow;
    logic [CW-1:0] r_ccol;
    logic          r_rev;

    tscb_pkg::t_mode   r_mode;
    logic [RW-1:0]     r_cur_r, r_end_r, r_b0, r_b1;
    logic [CW-1:0]     r_cur_c, r_l, r_r;
    logic              r_down, r_bpend;
    logic signed [9:0] r_off;
    logic [7:0]        r_wch;
    logic [1:0]        r_wst;
    logic [1:0]        r_rep;

    logic [7:0] r_res_ch;
    logic [1:0] r_res_st;
    logic       r_res_mk, r_res_row;

    logic [AW-1:0] r_clr;
    logic [9:0]    r_rd_cs;
    logic          r_rd_mk;

    logic       r_ovalid;
    logic [4:0] r_o_row;
    logic [6:0] r_o_col;
    logic [7:0] r_o_ch;
    logic [1:0] r_o_st;
    logic       r_o_mk, r_o_rowchg;

    // setup decode
    logic signed [9:0] s_t, s_l, s_b, s_r, s_h, s_u, s_au;
    logic              s_ne, s_cell, s_row, s_print, s_work;

    always_comb begin
        s_t = (r_rt == 8'd0) ? 10'sd0 : $signed({2'b00, r_rt}) - 10'sd1;
        s_l = (r_cl == 8'd0) ? 10'sd0 : $signed({2'b00, r_cl}) - 10'sd1;
        s_b = $signed({4'b0000, r_rb}) - 10'sd1;
        if (s_b > ROW_MAX) s_b = ROW_MAX;
        s_r = $signed({2'b00, r_cr}) - 10'sd1;
        if (s_r > COL_MAX) s_r = COL_MAX;
        s_ne = (s_t <= s_b) && (s_l <= s_r);
        s_h  = s_b - s_t + 10'sd1;
        s_u  = {{3{r_su[6]}}, r_su};
        if (s_u > s_h)  s_u = s_h;
        if (s_u < -s_h) s_u = -s_h;
        s_au   = (s_u < 10'sd0) ? -s_u : s_u;
        s_row  = (r_rt != 8'd0) && (s_t <= ROW_MAX);
        s_cell = s_row && (r_cl != 8'd0) && (s_l <= COL_MAX);
        s_print = ((r_ch >= tscb_pkg::CH_SPACE) && (r_ch <= tscb_pkg::CH_PRINT_MAX))
                  || (r_ch >= tscb_pkg::CH_HIGH_MIN);
        unique case (r_func)
            tscb_pkg::FN_PUT: s_work = s_print || (r_ch == tscb_pkg::CH_GAP)
                                       || (r_ch == tscb_pkg::CH_INDENT);
            tscb_pkg::FN_PICTURE, tscb_pkg::FN_READ: s_work = s_cell;
            tscb_pkg::FN_ERASE:  s_work = s_ne;
            tscb_pkg::FN_SCROLL: s_work = s_ne && (s_u != 10'sd0);
            tscb_pkg::FN_QUERY:  s_work = s_row;
            default:             s_work = 1'b0;
        endcase
    end

    // addresses
    logic [RW-1:0]     w_wr_row, w_rd_row;
    logic [CW-1:0]     w_wr_col;
    logic signed [9:0] w_src;
    logic [AW-1:0]     w_rd_addr, w_addr;
    logic              w_at_end;

    always_comb begin
        w_wr_row  = (r_mode == tscb_pkg::M_PUT) ? r_crow : r_cur_r;
        w_wr_col  = (r_mode == tscb_pkg::M_PUT) ? r_ccol : r_cur_c;
        w_src     = $signed({{(10 - RW){1'b0}}, r_cur_r}) + r_off;
        w_rd_row  = (r_mode == tscb_pkg::M_MOVE) ? RW'(w_src) : w_wr_row;
        w_rd_addr = {w_rd_row, w_wr_col};
        w_at_end  = (r_cur_c == r_r) && (r_cur_r == r_end_r);
    end

    // memory write port
    logic       w_we_cs, w_we_mk, w_mk;
    logic [9:0] w_cs;

    always_comb begin
        w_we_cs = 1'b0;
        w_we_mk = 1'b0;
        w_addr  = {w_wr_row, w_wr_col};
        w_cs    = {r_wch, r_wst};
        w_mk    = (r_rd_cs != {r_wch, r_wst});
        priority if (i_ctl.clr_init) begin
            w_we_cs = 1'b1;
            w_we_mk = 1'b1;
            w_addr  = r_clr;
            w_cs    = {tscb_pkg::CH_SPACE, tscb_pkg::ST_NORMAL};
            w_mk    = 1'b0;
        end else if (i_ctl.mclr) begin
            w_we_mk = 1'b1;
            w_addr  = r_clr;
            w_mk    = 1'b0;
        end else if (i_ctl.step) begin
            unique case (r_mode)
                tscb_pkg::M_SET, tscb_pkg::M_PUT: begin
                    w_we_cs = 1'b1;
                    w_we_mk = 1'b1;
                end
                tscb_pkg::M_MOVE: begin
                    w_we_cs = 1'b1;
                    w_we_mk = 1'b1;
                    w_cs    = r_rd_cs;
                    w_mk    = r_rd_mk;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_cs) mem_cs[w_addr] <= w_cs;
        if (w_we_mk) mem_mk[w_addr] <= w_mk;
        r_rd_cs <= mem_cs[w_rd_addr];
        r_rd_mk <= mem_mk[w_rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crow   <= '0;
            r_ccol   <= '0;
            r_rev    <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.clr_init || i_ctl.mclr) r_clr <= r_clr + 1'b1;
            if (i_ctl.load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_ctl.setup) begin
                if (r_func == tscb_pkg::FN_CURSOR) begin
                    r_crow <= RW'((s_t > ROW_MAX) ? ROW_MAX : s_t);
                    r_ccol <= CW'((s_l > COL_MAX) ? COL_MAX : s_l);
                end
                if (r_func == tscb_pkg::FN_STYLE) r_rev <= r_sty;
            end
            // advance the cursor after each put, wrap at the right edge,
            // hold at the bottom-right cell
            if (i_ctl.step && (r_mode == tscb_pkg::M_PUT)) begin
                if (r_ccol == CW'(COLS - 1)) begin
                    if (r_crow != RW'(ROWS - 1)) begin
                        r_crow <= r_crow + 1'b1;
                        r_ccol <= '0;
                    end
                end else begin
                    r_ccol <= r_ccol + 1'b1;
                end
            end
        end
    end

    // command fields, walker and results
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_cmd.valid) begin
            r_func <= i_cmd.func;
            r_ch   <= i_cmd.char_code;
            r_sty  <= i_cmd.style_word[0];
            r_rt   <= i_cmd.row_top;
            r_cl   <= i_cmd.col_left;
            r_rb   <= i_cmd.row_bottom;
            r_cr   <= i_cmd.col_right;
            r_su   <= i_cmd.shift_units;
        end
        if (i_ctl.setup) begin
            r_res_ch  <= '0;
            r_res_st  <= '0;
            r_res_mk  <= 1'b0;
            r_res_row <= 1'b0;
            r_mode    <= tscb_pkg::M_SET;
            r_cur_r   <= RW'(s_t);
            r_end_r   <= RW'(s_b);
            r_cur_c   <= CW'(s_l);
            r_l       <= CW'(s_l);
            r_r       <= CW'(s_r);
            r_down    <= 1'b0;
            r_bpend   <= 1'b0;
            r_off     <= '0;
            r_wch     <= tscb_pkg::CH_SPACE;
            r_wst     <= {1'b0, r_rev};
            r_rep     <= 2'd1;
            r_b0      <= RW'(s_t);
            r_b1      <= RW'(s_b);
            unique case (r_func)
                tscb_pkg::FN_PUT: begin
                    r_mode <= tscb_pkg::M_PUT;
                    priority if (s_print) begin
                        r_wch <= r_ch;
                    end else if (r_ch == tscb_pkg::CH_GAP) begin
                        r_rep <= 2'd2;
                    end else begin
                        r_rep <= 2'd3;
                    end
                end
                tscb_pkg::FN_PICTURE, tscb_pkg::FN_READ: begin
                    r_mode  <= (r_func == tscb_pkg::FN_READ) ? tscb_pkg::M_READ
                                                             : tscb_pkg::M_SET;
                    r_end_r <= RW'(s_t);
                    r_r     <= CW'(s_l);
                    r_wch   <= r_ch;
                    r_wst   <= tscb_pkg::ST_PICTURE;
                end
                tscb_pkg::FN_QUERY: begin
                    r_mode  <= tscb_pkg::M_QUERY;
                    r_end_r <= RW'(s_t);
                    r_cur_c <= '0;
                    r_l     <= '0;
                    r_r     <= CW'(COLS - 1);
                end
                tscb_pkg::FN_SCROLL: begin
                    // move the kept rows first, then blank the vacated rows
                    if (s_au < s_h) begin
                        r_mode  <= tscb_pkg::M_MOVE;
                        r_bpend <= 1'b1;
                        if (s_u > 10'sd0) begin
                            r_end_r <= RW'(s_b - s_u);
                            r_off   <= s_u;
                            r_b0    <= RW'(s_b - s_u + 10'sd1);
                        end else begin
                            r_cur_r <= RW'(s_b);
                            r_end_r <= RW'(s_t + s_au);
                            r_down  <= 1'b1;
                            r_off   <= s_u;
                            r_b1    <= RW'(s_t + s_au - 10'sd1);
                        end
                    end
                end
                default: ;
            endcase
        end else if (i_ctl.step) begin
            unique case (r_mode)
                tscb_pkg::M_PUT: r_rep <= r_rep - 2'd1;
                tscb_pkg::M_READ: begin
                    r_res_ch <= r_rd_cs[9:2];
                    r_res_st <= r_rd_cs[1:0];
                    r_res_mk <= r_rd_mk;
                end
                default: begin
                    if ((r_mode == tscb_pkg::M_QUERY) && r_rd_mk
                        && (r_rd_cs[9:2] != tscb_pkg::CH_SPACE)
                        && (r_rd_cs[1:0] != tscb_pkg::ST_PICTURE)) begin
                        r_res_row <= 1'b1;
                    end
                    if (r_cur_c == r_r) begin
                        r_cur_c <= r_l;
                        if (r_cur_r == r_end_r) begin
                            if (r_bpend) begin
                                r_mode  <= tscb_pkg::M_SET;
                                r_bpend <= 1'b0;
                                r_down  <= 1'b0;
                                r_off   <= '0;
                                r_cur_r <= r_b0;
                                r_end_r <= r_b1;
                            end
                        end else begin
                            r_cur_r <= r_down ? r_cur_r - 1'b1 : r_cur_r + 1'b1;
                        end
                    end else begin
                        r_cur_c <= r_cur_c + 1'b1;
                    end
                end
            endcase
        end
        if (i_ctl.load) begin
            r_o_row    <= 5'(r_crow);
            r_o_col    <= 7'(r_ccol);
            r_o_ch     <= r_res_ch;
            r_o_st     <= r_res_st;
            r_o_mk     <= r_res_mk;
            r_o_rowchg <= r_res_row;
        end
    end

    always_comb begin
        o_sts.in_valid = i_cmd.valid;
        o_sts.clr_last = &r_clr;
        o_sts.work     = s_work;
        o_sts.mclr_req = (r_func == tscb_pkg::FN_CLEAR);
        o_sts.out_free = !r_ovalid || o_rsp.ready;
        unique case (r_mode)
            tscb_pkg::M_PUT:  o_sts.last = (r_rep == 2'd1);
            tscb_pkg::M_READ: o_sts.last = 1'b1;
            default:          o_sts.last = w_at_end && !r_bpend;
        endcase
    end

    assign i_cmd.ready          = i_ctl.accept;
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.cursor_row_out = r_o_row;
    assign o_rsp.cursor_col_out = r_o_col;
    assign o_rsp.rd_char        = r_o_ch;
    assign o_rsp.rd_style       = r_o_st;
    assign o_rsp.cell_changed   = r_o_mk;
    assign o_rsp.row_changed    = r_o_rowchg;

endmodule

// ===== rtl/text_screen_cell_buffer_top.sv =====
// ----------------------------------------------------------------------------
// text_screen_cell_buffer_top: character-cell text screen buffer
// Holds character, style and changed mark per cell and runs one screen
// command per transfer, answering with the cursor and any read result.
// ----------------------------------------------------------------------------
//
//  channel   dir  modport  carries
//  i_cmd     in   sink     func, char, style, rectangle, shift amount
//  o_rsp     out  source   cursor, read cell, row query answer
//
// One command at a time. Set cursor, set style and empty or out-of-range
// commands go from setup straight to the result; each cell touched adds a
// read state then a write state (registered read, then write of the cell
// memory): a character touches one cell, indent three, erase/scroll every
// cell of the rectangle, a row query COLS cells; clear marks steps through
// all 2^clog2(ROWS) * 2^clog2(COLS) marks. Reset: a clearing pass over all
// cells fills the screen with spaces; no command is taken until it ends.
// Stalls: the result register frees the command side; a new command is
// taken while the previous result waits, and the block holds only when a
// second result is ready behind an untaken one.
module text_screen_cell_buffer_top #(
    parameter int ROWS = tscb_pkg::ROWS_DEF,
    parameter int COLS = tscb_pkg::COLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tscb_cmd_if.sink   i_cmd,
    tscb_rsp_if.source o_rsp
);

    tscb_pkg::t_cmd    ctl;
    tscb_pkg::t_status sts;

    // sequencer: owns the state, issues one command group per cycle
    tscb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (ctl)
    );

    // datapath: memories, cursor, walker and the result register
    tscb_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_rsp   (o_rsp),
        .i_ctl   (ctl),
        .o_sts   (sts)
    );

    // drop ready right after a transfer: one command in flight
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command taken while another is in flight");

    // load a result only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |-> sts.out_free)
        else $error("result overwrote an untaken result");

    // hold the result until it is taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.rd_char)))
        else $error("result dropped before transfer");

    // never accept in the same cycle as a load or a step
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.accept && (ctl.load || ctl.step)))
        else $error("accept overlaps command execution");

endmodule

// ===== sim/tscb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscb_checker: screen model and result comparator
// Watches the command and result channels, keeps its own copy of the
// screen, and compares every result with the oldest predicted one.
// ----------------------------------------------------------------------------
module tscb_checker #(
    parameter int ROWS = 32,
    parameter int COLS = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tscb_cmd_if.sink  cmd_mon,
    tscb_rsp_if.sink  rsp_mon,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic [4:0] crow;
        logic [6:0] ccol;
        logic [7:0] ch;
        logic [1:0] st;
        logic       chg;
        logic       rowq;
    } t_screen_rsp;

    logic [7:0] scr_char [ROWS][COLS];
    logic [1:0] scr_style[ROWS][COLS];
    logic       scr_mark [ROWS][COLS];
    int         cur_row, cur_col;
    logic       rev_mode;
    t_screen_rsp rsp_queue[$];

    assign o_pending = rsp_queue.size();

    function automatic void store_cell(int r, int c, logic [7:0] ch, logic [1:0] st);
        if (r < 0 || c < 0 || r >= ROWS || c >= COLS) return;
        scr_mark[r][c]  = (scr_char[r][c] != ch) || (scr_style[r][c] != st);
        scr_char[r][c]  = ch;
        scr_style[r][c] = st;
    endfunction

    function automatic void blank_area(int r0, int r1, int c0, int c1);
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                store_cell(r, c, tscb_pkg::CH_SPACE, {1'b0, rev_mode});
    endfunction

    function automatic void put_at_cursor(logic [7:0] ch);
        store_cell(cur_row, cur_col, ch, {1'b0, rev_mode});
        cur_col++;
        if (cur_col >= COLS) begin
            if (cur_row >= ROWS - 1) cur_col = COLS - 1;
            else begin
                cur_row++;
                cur_col = 0;
            end
        end
    endfunction

    function automatic void move_one(int dr, int sr, int c);
        scr_char[dr][c]  = scr_char[sr][c];
        scr_style[dr][c] = scr_style[sr][c];
        scr_mark[dr][c]  = scr_mark[sr][c];
    endfunction

    function automatic t_screen_rsp run_command();
        t_screen_rsp res;
        int t, l, b, r, u, h, rt, cl;
        bit nonempty;
        res = '0;
        rt = cmd_mon.row_top;
        cl = cmd_mon.col_left;
        t = rt - 1; l = cl - 1;
        b = int'(cmd_mon.row_bottom) - 1;
        r = int'(cmd_mon.col_right) - 1;
        if (t < 0) t = 0;
        if (l < 0) l = 0;
        if (b > ROWS - 1) b = ROWS - 1;
        if (r > COLS - 1) r = COLS - 1;
        nonempty = (t <= b) && (l <= r);
        case (cmd_mon.func)
            tscb_pkg::FN_PUT: begin
                if ((cmd_mon.char_code >= tscb_pkg::CH_SPACE
                     && cmd_mon.char_code <= tscb_pkg::CH_PRINT_MAX)
                    || cmd_mon.char_code >= tscb_pkg::CH_HIGH_MIN)
                    put_at_cursor(cmd_mon.char_code);
                else if (cmd_mon.char_code == tscb_pkg::CH_GAP)
                    repeat (2) put_at_cursor(tscb_pkg::CH_SPACE);
                else if (cmd_mon.char_code == tscb_pkg::CH_INDENT)
                    repeat (3) put_at_cursor(tscb_pkg::CH_SPACE);
            end
            tscb_pkg::FN_CURSOR: begin
                cur_row = (rt == 0) ? 0 : ((rt - 1 > ROWS - 1) ? ROWS - 1 : rt - 1);
                cur_col = (cl == 0) ? 0 : ((cl - 1 > COLS - 1) ? COLS - 1 : cl - 1);
            end
            tscb_pkg::FN_STYLE: rev_mode = cmd_mon.style_word[0];
            tscb_pkg::FN_PICTURE: if (rt >= 1 && cl >= 1)
                store_cell(rt - 1, cl - 1, cmd_mon.char_code, tscb_pkg::ST_PICTURE);
            tscb_pkg::FN_ERASE: if (nonempty) blank_area(t, b, l, r);
            tscb_pkg::FN_SCROLL: if (nonempty) begin
                u = cmd_mon.shift_units;
                h = b - t + 1;
                if (u > h) u = h;
                if (u < -h) u = -h;
                if (u > 0) begin
                    for (int k = t; k <= b - u; k++)
                        for (int c = l; c <= r; c++) move_one(k, k + u, c);
                    blank_area(b - u + 1, b, l, r);
                end else if (u < 0) begin
                    u = -u;
                    for (int k = b; k >= t + u; k--)
                        for (int c = l; c <= r; c++) move_one(k, k - u, c);
                    blank_area(t, t + u - 1, l, r);
                end
            end
            tscb_pkg::FN_READ: if (rt >= 1 && cl >= 1 && rt <= ROWS && cl <= COLS) begin
                res.ch  = scr_char[rt-1][cl-1];
                res.st  = scr_style[rt-1][cl-1];
                res.chg = scr_mark[rt-1][cl-1];
            end
            tscb_pkg::FN_QUERY: if (rt >= 1 && rt <= ROWS) begin
                for (int j = 0; j < COLS; j++)
                    if (scr_mark[rt-1][j] && scr_char[rt-1][j] != tscb_pkg::CH_SPACE &&
                        scr_style[rt-1][j] != tscb_pkg::ST_PICTURE)
                        res.rowq = 1'b1;
            end
            tscb_pkg::FN_CLEAR: begin
                foreach (scr_mark[i, j]) scr_mark[i][j] = 1'b0;
            end
            default: ;
        endcase
        res.crow = cur_row[4:0];
        res.ccol = cur_col[6:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_screen_rsp want;
        if (!i_rst_n) begin
            foreach (scr_char[i, j]) begin
                scr_char[i][j]  = tscb_pkg::CH_SPACE;
                scr_style[i][j] = tscb_pkg::ST_NORMAL;
                scr_mark[i][j]  = 1'b0;
            end
            cur_row = 0;
            cur_col = 0;
            rev_mode = 1'b0;
            o_fail_count = 0;
        end else begin
            if (cmd_mon.valid && cmd_mon.ready) rsp_queue.push_back(run_command());
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (rsp_queue.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (rsp_mon.cursor_row_out !== want.crow) begin
                        $error("cursor_row_out: expected %0d, got %0d", want.crow,
                               rsp_mon.cursor_row_out);
                        o_fail_count++;
                    end
                    if (rsp_mon.cursor_col_out !== want.ccol) begin
                        $error("cursor_col_out: expected %0d, got %0d", want.ccol,
                               rsp_mon.cursor_col_out);
                        o_fail_count++;
                    end
                    if (rsp_mon.rd_char !== want.ch) begin
                        $error("rd_char: expected %0h, got %0h", want.ch,
                               rsp_mon.rd_char);
                        o_fail_count++;
                    end
                    if (rsp_mon.rd_style !== want.st) begin
                        $error("rd_style: expected %0d, got %0d", want.st,
                               rsp_mon.rd_style);
                        o_fail_count++;
                    end
                    if (rsp_mon.cell_changed !== want.chg) begin
                        $error("cell_changed: expected %0d, got %0d", want.chg,
                               rsp_mon.cell_changed);
                        o_fail_count++;
                    end
                    if (rsp_mon.row_changed !== want.rowq) begin
                        $error("row_changed: expected %0d, got %0d", want.rowq,
                               rsp_mon.row_changed);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb_text_screen_cell_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_screen_cell_buffer_top: screen buffer testbench
// Drives directed and random screen commands under varying idle and stall
// patterns; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_text_screen_cell_buffer_top;

    // Slowest commands are full-screen erase and scroll, a read and a write per
    // cell; allow many times that, plus the clearing pass after reset.
    localparam int STALL_LIMIT = 100000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    int   quiet_cycles;

    tscb_cmd_if cmd_ch();
    tscb_rsp_if rsp_ch();

    text_screen_cell_buffer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    tscb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd_mon      (cmd_ch),
        .rsp_mon      (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Receiver: at each falling edge, pick whether to stall this cycle.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run when nothing transfers for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Send one command; hold it until the transfer, then drop valid only if
    // the sender idles next.
    task automatic send_cmd(logic [3:0] fn, logic [7:0] ch, logic [7:0] sw,
                            logic [7:0] rt, logic [7:0] cl, logic [5:0] rb,
                            logic [7:0] cr, logic signed [6:0] su);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.func        <= fn;
        cmd_ch.char_code   <= ch;
        cmd_ch.style_word  <= sw;
        cmd_ch.row_top     <= rt;
        cmd_ch.col_left    <= cl;
        cmd_ch.row_bottom  <= rb;
        cmd_ch.col_right   <= cr;
        cmd_ch.shift_units <= su;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send_simple(logic [3:0] fn, logic [7:0] ch, logic [7:0] rt,
                               logic [7:0] cl);
        send_cmd(fn, ch, 8'($urandom), rt, cl, 6'($urandom), 8'($urandom),
                 7'($urandom));
    endtask

    // Random command, weighted toward writes into a small window so that
    // reads, queries and scrolls see changed cells.
    task automatic send_random();
        int sel;
        logic [3:0] fn;
        logic [7:0] rt, cl, cr;
        logic [5:0] rb;
        logic signed [6:0] su;
        sel = $urandom_range(99);
        if (sel < 35) fn = tscb_pkg::FN_PUT;
        else if (sel < 45) fn = tscb_pkg::FN_CURSOR;
        else if (sel < 50) fn = tscb_pkg::FN_STYLE;
        else if (sel < 58) fn = tscb_pkg::FN_PICTURE;
        else if (sel < 64) fn = tscb_pkg::FN_ERASE;
        else if (sel < 72) fn = tscb_pkg::FN_SCROLL;
        else if (sel < 86) fn = tscb_pkg::FN_READ;
        else if (sel < 94) fn = tscb_pkg::FN_QUERY;
        else if (sel < 95) fn = tscb_pkg::FN_CLEAR;
        else fn = 4'($urandom_range(15));
        if ($urandom_range(9) < 8) begin
            rt = 8'($urandom_range(6));
            cl = 8'($urandom_range(10));
            rb = 6'($urandom_range(8));
            cr = 8'($urandom_range(12));
        end else begin
            rt = 8'($urandom);
            cl = 8'($urandom);
            rb = 6'($urandom);
            cr = 8'($urandom);
        end
        if (fn == tscb_pkg::FN_CURSOR && $urandom_range(3) == 0) begin
            rt = 8'($urandom_range(30, 33));
            cl = 8'($urandom_range(124, 130));
        end
        su = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($signed($urandom_range(8)) - 4);
        send_cmd(fn, 8'($urandom), 8'($urandom), rt, cl, rb, cr, su);
    endtask

    initial begin
        int limit;
        i_rst_n = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        rsp_ch.ready = 1'b1;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = tscb_pkg::FN_PUT;
        cmd_ch.char_code = '0;
        cmd_ch.style_word = '0;
        cmd_ch.row_top = '0;
        cmd_ch.col_left = '0;
        cmd_ch.row_bottom = '0;
        cmd_ch.col_right = '0;
        cmd_ch.shift_units = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every function, field extremes, wrap and hold.
        send_simple(tscb_pkg::FN_PUT, 8'h41, 0, 0);
        send_simple(tscb_pkg::FN_PUT, tscb_pkg::CH_GAP, 0, 0);
        send_simple(tscb_pkg::FN_PUT, tscb_pkg::CH_INDENT, 0, 0);
        send_simple(tscb_pkg::FN_PUT, 8'h07, 0, 0);
        send_simple(tscb_pkg::FN_PUT, 8'hFF, 0, 0);
        send_cmd(tscb_pkg::FN_STYLE, 0, 8'hFF, 0, 0, 0, 0, 0);
        send_simple(tscb_pkg::FN_PUT, 8'h7E, 0, 0);
        send_simple(tscb_pkg::FN_PUT, 8'h7F, 0, 0);
        send_simple(tscb_pkg::FN_CURSOR, 0, 8'd1, 8'd127);
        send_simple(tscb_pkg::FN_PUT, 8'hA0, 0, 0);
        send_simple(tscb_pkg::FN_PUT, tscb_pkg::CH_INDENT, 0, 0);
        send_simple(tscb_pkg::FN_CURSOR, 0, 8'd255, 8'd255);
        send_simple(tscb_pkg::FN_PUT, tscb_pkg::CH_INDENT, 0, 0);
        send_simple(tscb_pkg::FN_PICTURE, 8'h55, 8'd1, 8'd1);
        send_simple(tscb_pkg::FN_PICTURE, 8'h55, 8'd255, 8'd200);
        send_simple(tscb_pkg::FN_READ, 0, 8'd1, 8'd1);
        send_simple(tscb_pkg::FN_READ, 0, 8'd255, 8'd128);
        send_simple(tscb_pkg::FN_QUERY, 0, 8'd1, 0);
        send_simple(tscb_pkg::FN_QUERY, 0, 8'd32, 0);
        send_simple(tscb_pkg::FN_QUERY, 0, 8'd0, 0);
        send_cmd(tscb_pkg::FN_SCROLL, 0, 0, 8'd1, 8'd1, 6'd3, 8'd4, 7'sd63);
        send_cmd(tscb_pkg::FN_SCROLL, 0, 0, 8'd1, 8'd1, 6'd3, 8'd130, 7'sh40);
        send_cmd(tscb_pkg::FN_ERASE, 0, 0, 8'd0, 8'd0, 6'd1, 8'd255, 0);
        send_cmd(tscb_pkg::FN_ERASE, 0, 0, 8'd5, 8'd1, 6'd2, 8'd3, 0);
        send_simple(tscb_pkg::FN_CLEAR, 0, 0, 0);
        send_simple(4'd15, 0, 0, 0);
        send_cmd(tscb_pkg::FN_STYLE, 0, 8'h00, 0, 0, 0, 0, 0);

        // Random phases with different idle and stall mixes.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                3: begin idle_pct = 11; stall_pct = 11; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            repeat (255) send_random();
        end
        cmd_ch.valid <= 1'b0;

        limit = 0;
        while (pending != 0 && limit < STALL_LIMIT) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
